// ===== hdl/bscsd_pkg.sv =====
// ----------------------------------------------------------------------------
// bscsd_pkg
// Shared types, constants and digit helpers of the two-button 24-hour clock.
// ----------------------------------------------------------------------------
package bscsd_pkg;

	localparam int unsigned HourW    = 5;
	localparam int unsigned MinuteW  = 6;
	localparam int unsigned SecondW  = 6;
	localparam int unsigned SubtickW = 8;
	localparam int unsigned SegW     = 8;

	localparam logic [HourW-1:0]    MaxHour          = 5'd23;
	localparam logic [MinuteW-1:0]  MaxMinute        = 6'd59;
	localparam logic [SecondW-1:0]  MaxSecond        = 6'd59;
	localparam logic [SubtickW-1:0] DefaultSubticks  = 8'd60;

	// register byte addresses
	localparam int unsigned PaddrW = 3;
	localparam logic [PaddrW-1:0] AddrSubticks = 3'd0;

	// stream widths
	localparam int unsigned InDataW  = 24;
	localparam int unsigned InUserW  = 2;
	localparam int unsigned OutDataW = 56;

	// output tdata field positions
	localparam int unsigned ColonBit   = 32;
	localparam int unsigned FieldLsb   = 33;
	localparam int unsigned HourLsb    = 35;
	localparam int unsigned MinuteLsb  = 40;
	localparam int unsigned SecondLsb  = 46;

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_BUTTON = 2'd1,
		OP_SET    = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		SEL_NONE   = 2'd0,
		SEL_HOUR   = 2'd1,
		SEL_MINUTE = 2'd2
	} sel_field_t;

	// segment a at bit 0 through g at bit 6, dp never lit
	function automatic logic [SegW-1:0] seg_pattern(input logic [3:0] digit);
		logic [SegW-1:0] pat;
		unique case (digit)
			4'd0:    pat = 8'h3F;
			4'd1:    pat = 8'h06;
			4'd2:    pat = 8'h5B;
			4'd3:    pat = 8'h4F;
			4'd4:    pat = 8'h66;
			4'd5:    pat = 8'h6D;
			4'd6:    pat = 8'h7D;
			4'd7:    pat = 8'h07;
			4'd8:    pat = 8'h7F;
			4'd9:    pat = 8'h6F;
			default: pat = 8'h00;
		endcase
		return pat;
	endfunction

	// tens digit of a value below 64 by comparison
	function automatic logic [2:0] tens_of(input logic [5:0] value);
		logic [2:0] t;
		if (value >= 6'd60) begin
			t = 3'd6;
		end else if (value >= 6'd50) begin
			t = 3'd5;
		end else if (value >= 6'd40) begin
			t = 3'd4;
		end else if (value >= 6'd30) begin
			t = 3'd3;
		end else if (value >= 6'd20) begin
			t = 3'd2;
		end else if (value >= 6'd10) begin
			t = 3'd1;
		end else begin
			t = 3'd0;
		end
		return t;
	endfunction

	function automatic logic [3:0] ones_of(input logic [5:0] value);
		logic [2:0] t;
		logic [6:0] tens_x10;
		t = tens_of(value);
		tens_x10 = {1'b0, t, 3'b000} + {3'b000, t, 1'b0};
		return 4'(value - tens_x10[5:0]);
	endfunction

endpackage

// ===== hdl/button_set_clock_with_segment_digits_unit.sv =====
// ----------------------------------------------------------------------------
// button_set_clock_with_segment_digits_unit
// 24-hour clock with two-button setting and a four-digit seven-segment view.
// ----------------------------------------------------------------------------
// Every input transfer (tick, button sample or set time) yields one result
// transfer. The time state and the output register are both loaded at the edge
// that takes the item, so the result shows in the following cycle and the block
// takes one item per clock; the only limit is the single output register, which
// accepts a new item whenever it is empty or being drained in the same cycle.
// The user writes subticks_per_second (byte address 0) over the APB port only
// while no item is in flight; the block does not check. Zero behaves like one.
module button_set_clock_with_segment_digits_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	// APB configuration
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [bscsd_pkg::PaddrW-1:0]       paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	// input stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// mode_pressed[0], increment_pressed[1], load_hour[6:2],
	// load_minute[12:7], load_second[18:13], zero fill [23:19]
	input  logic [bscsd_pkg::InDataW-1:0]      s_tdata,
	// opcode[1:0]
	input  logic [bscsd_pkg::InUserW-1:0]      s_tuser,
	// result stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// hour_tens_segments[7:0], hour_ones_segments[15:8],
	// minute_tens_segments[23:16], minute_ones_segments[31:24], colon_on[32],
	// setting_field[34:33], hour_now[39:35], minute_now[45:40],
	// second_now[51:46], zero fill [55:52]
	output logic [bscsd_pkg::OutDataW-1:0]     m_tdata
);

	logic [bscsd_pkg::SubtickW-1:0] spsec_q;
	logic [bscsd_pkg::HourW-1:0]    hour_q,    hour_d;
	logic [bscsd_pkg::MinuteW-1:0]  minute_q,  minute_d;
	logic [bscsd_pkg::SecondW-1:0]  second_q,  second_d;
	logic [bscsd_pkg::SubtickW-1:0] subtick_q, subtick_d;
	bscsd_pkg::sel_field_t          sel_q,     sel_d;

	logic                           out_valid_q;
	logic [bscsd_pkg::OutDataW-1:0] out_data_q;
	logic [bscsd_pkg::OutDataW-1:0] out_data_d;

	logic                           accept;
	logic                           cfg_wr;
	logic                           mode_pressed;
	logic                           increment_pressed;
	logic [bscsd_pkg::HourW-1:0]    load_hour;
	logic [bscsd_pkg::MinuteW-1:0]  load_minute;
	logic [bscsd_pkg::SecondW-1:0]  load_second;
	logic [bscsd_pkg::SubtickW:0]   subtick_inc;
	logic [5:0]                     hour_ext;
	logic                           colon;

	assign mode_pressed      = s_tdata[0];
	assign increment_pressed = s_tdata[1];
	assign load_hour         = s_tdata[6:2];
	assign load_minute       = s_tdata[12:7];
	assign load_second       = s_tdata[18:13];

	// ---- configuration ----
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
	assign prdata = (paddr[2] == 1'b0) ? {24'd0, spsec_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spsec_q <= bscsd_pkg::DefaultSubticks;
		end else if (cfg_wr) begin
			spsec_q <= pwdata[bscsd_pkg::SubtickW-1:0];
		end
	end

	// ---- handshake ----
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// ---- next time state ----
	assign subtick_inc = {1'b0, subtick_q} + 9'd1;

	always_comb begin
		hour_d    = hour_q;
		minute_d  = minute_q;
		second_d  = second_q;
		subtick_d = subtick_q;
		sel_d     = sel_q;
		unique case (bscsd_pkg::opcode_t'(s_tuser))
			bscsd_pkg::OP_TICK: begin
				if (subtick_inc >= {1'b0, spsec_q}) begin
					subtick_d = '0;
					if (second_q == bscsd_pkg::MaxSecond) begin
						second_d = '0;
						if (minute_q == bscsd_pkg::MaxMinute) begin
							minute_d = '0;
							hour_d = (hour_q == bscsd_pkg::MaxHour) ? '0 : hour_q + 5'd1;
						end else begin
							minute_d = minute_q + 6'd1;
						end
					end else begin
						second_d = second_q + 6'd1;
					end
				end else begin
					subtick_d = subtick_inc[bscsd_pkg::SubtickW-1:0];
				end
			end
			bscsd_pkg::OP_BUTTON: begin
				if (mode_pressed || increment_pressed) begin
					priority if (sel_q == bscsd_pkg::SEL_NONE) begin
						hour_d    = '0;
						minute_d  = '0;
						second_d  = '0;
						subtick_d = '0;
						sel_d     = bscsd_pkg::SEL_HOUR;
					end else if (mode_pressed && sel_q == bscsd_pkg::SEL_HOUR) begin
						sel_d = bscsd_pkg::SEL_MINUTE;
					end else if (increment_pressed) begin
						// increment wraps the selected field and restarts the second
						if (sel_q == bscsd_pkg::SEL_HOUR) begin
							hour_d = (hour_q == bscsd_pkg::MaxHour) ? '0 : hour_q + 5'd1;
						end else begin
							minute_d = (minute_q == bscsd_pkg::MaxMinute) ? '0
							         : minute_q + 6'd1;
						end
						second_d  = '0;
						subtick_d = '0;
					end else begin
						sel_d = bscsd_pkg::SEL_NONE;
					end
				end
			end
			bscsd_pkg::OP_SET: begin
				hour_d   = (load_hour > bscsd_pkg::MaxHour) ? bscsd_pkg::MaxHour : load_hour;
				minute_d = (load_minute > bscsd_pkg::MaxMinute) ? bscsd_pkg::MaxMinute
				         : load_minute;
				second_d = (load_second > bscsd_pkg::MaxSecond) ? bscsd_pkg::MaxSecond
				         : load_second;
			end
			default: begin
			end
		endcase
	end

	// ---- result word ----
	assign hour_ext = {1'b0, hour_d};
	assign colon    = second_d[0] && (sel_d == bscsd_pkg::SEL_NONE);

	always_comb begin
		out_data_d = '0;
		out_data_d[7:0]   = bscsd_pkg::seg_pattern({1'b0, bscsd_pkg::tens_of(hour_ext)});
		out_data_d[15:8]  = bscsd_pkg::seg_pattern(bscsd_pkg::ones_of(hour_ext));
		out_data_d[23:16] = bscsd_pkg::seg_pattern({1'b0, bscsd_pkg::tens_of(minute_d)});
		out_data_d[31:24] = bscsd_pkg::seg_pattern(bscsd_pkg::ones_of(minute_d));
		out_data_d[bscsd_pkg::ColonBit]                   = colon;
		out_data_d[bscsd_pkg::FieldLsb +: 2]              = sel_d;
		out_data_d[bscsd_pkg::HourLsb +: bscsd_pkg::HourW]     = hour_d;
		out_data_d[bscsd_pkg::MinuteLsb +: bscsd_pkg::MinuteW] = minute_d;
		out_data_d[bscsd_pkg::SecondLsb +: bscsd_pkg::SecondW] = second_d;
	end

	// ---- registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hour_q    <= '0;
			minute_q  <= '0;
			second_q  <= '0;
			subtick_q <= '0;
			sel_q     <= bscsd_pkg::SEL_NONE;
		end else if (accept) begin
			hour_q    <= hour_d;
			minute_q  <= minute_d;
			second_q  <= second_d;
			subtick_q <= subtick_d;
			sel_q     <= sel_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= out_data_d;
		end
	end

endmodule

// ===== hdl/bscsd_checker.sv =====
// ----------------------------------------------------------------------------
// bscsd_checker
// Port-level checks of the clock unit, bound to the top level.
// ----------------------------------------------------------------------------
module bscsd_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [bscsd_pkg::OutDataW-1:0] m_tdata
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// every taken item shows a result in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("taken item gave no result");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[bscsd_pkg::HourLsb +: bscsd_pkg::HourW] <= bscsd_pkg::MaxHour)
		&& (m_tdata[bscsd_pkg::MinuteLsb +: bscsd_pkg::MinuteW] <= bscsd_pkg::MaxMinute)
		&& (m_tdata[bscsd_pkg::SecondLsb +: bscsd_pkg::SecondW] <= bscsd_pkg::MaxSecond))
		else $error("time out of range");

	// colon stays dark while setting, and no fourth setting code appears
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[bscsd_pkg::ColonBit] |->
		m_tdata[bscsd_pkg::FieldLsb +: 2] == bscsd_pkg::SEL_NONE)
		else $error("colon lit while setting");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[bscsd_pkg::FieldLsb +: 2] != 2'd3)
		else $error("bad setting field");

endmodule

bind button_set_clock_with_segment_digits_unit bscsd_checker u_bscsd_checker (.*);
